// ===== rtl/id_pool_allocator_defines.svh =====
`ifndef ID_POOL_ALLOCATOR_DEFINES_SVH
`define ID_POOL_ALLOCATOR_DEFINES_SVH

// Condition that must hold at every clock edge outside reset
`define IPA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ipa check failed: condition");

// Antecedent in one cycle implies consequent in the next
`define IPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipa check failed: next-cycle implication");

`endif

// ===== rtl/ipa_pkg.sv =====
package ipa_pkg;

  localparam int HANDLE_W     = 10;
  localparam int STATUS_W     = 2;
  localparam int S_DATA_W     = 16;
  localparam int M_DATA_W     = 16;
  localparam int ID_COUNT_DEF = 1024;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/ipa_ctrl.sv =====
module ipa_ctrl (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  ipa_pkg::sts_t sts,
  output ipa_pkg::cmd_t cmd
);
  import ipa_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    cmd.clear_step = 1'b0;
    cmd.accept     = 1'b0;
    cmd.commit     = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for room in the output register
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/ipa_datapath.sv =====
module ipa_datapath #(
  parameter int ID_COUNT = ipa_pkg::ID_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ipa_pkg::cmd_t                cmd,
  output ipa_pkg::sts_t                sts,
  input  logic [ipa_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ipa_pkg::M_DATA_W-1:0] m_tdata
);
  import ipa_pkg::*;

  localparam int IDX_W = $clog2(ID_COUNT);
  localparam int CNT_W = $clog2(ID_COUNT + 1);

  // storage
  logic                map_mem   [ID_COUNT];
  logic [HANDLE_W-1:0] stack_mem [ID_COUNT];

  // request and read-back registers
  op_t                 op_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                map_rd;
  logic [HANDLE_W-1:0] stack_rd;

  // pool counters
  logic [CNT_W-1:0]    free_count, free_count_next;
  logic [CNT_W-1:0]    high_water, high_water_next;
  logic [IDX_W-1:0]    clr_cnt;

  // output register
  logic [HANDLE_W-1:0] handle_out;
  status_t             status;

  // result and memory write controls
  logic [HANDLE_W-1:0] res_handle;
  status_t             res_status;
  logic                map_we;
  logic [IDX_W-1:0]    map_wa;
  logic                map_wd;
  logic                push;
  logic [HANDLE_W-1:0] s_handle;
  logic [IDX_W-1:0]    stack_top;

  assign s_handle  = s_tdata[HANDLE_W-1:0];
  assign stack_top = IDX_W'(free_count - CNT_W'(1));

  assign sts.clear_last = (clr_cnt == IDX_W'(ID_COUNT - 1));
  assign sts.out_free   = !m_tvalid || m_tready;

  // execute step: decide result, map update and push
  always_comb begin
    res_handle      = '0;
    res_status      = ST_OK;
    free_count_next = free_count;
    high_water_next = high_water;
    map_we          = 1'b0;
    map_wa          = clr_cnt;
    map_wd          = 1'b0;
    push            = 1'b0;
    if (cmd.clear_step) begin
      map_we = 1'b1;
    end else if (cmd.commit) begin
      if (op_q == OP_ALLOC) begin
        if (free_count != '0) begin
          // reuse most recently freed handle
          free_count_next = free_count - CNT_W'(1);
          res_handle      = stack_rd;
          map_we          = (32'(stack_rd) < ID_COUNT);
          map_wa          = IDX_W'(stack_rd);
          map_wd          = 1'b1;
        end else if (high_water < CNT_W'(ID_COUNT)) begin
          // fresh handle from the high-water mark
          high_water_next = high_water + CNT_W'(1);
          res_handle      = HANDLE_W'(high_water);
          map_we          = 1'b1;
          map_wa          = IDX_W'(high_water);
          map_wd          = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end else begin
        if ((32'(handle_q) < ID_COUNT) && map_rd) begin
          res_handle = handle_q;
          map_we     = 1'b1;
          map_wa     = IDX_W'(handle_q);
          map_wd     = 1'b0;
          if (free_count < CNT_W'(ID_COUNT)) begin
            push            = 1'b1;
            free_count_next = free_count + CNT_W'(1);
          end
        end else begin
          res_status = ST_NOT_IN_USE;
        end
      end
    end
  end

  // in-use map: one write port, registered read at accept
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (cmd.accept) begin
      map_rd <= map_mem[IDX_W'(s_handle)];
    end
  end

  // free stack: push at count, registered read of the top at accept
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[IDX_W'(free_count)] <= handle_q;
    end
    if (cmd.accept) begin
      stack_rd <= stack_mem[stack_top];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= op_t'(s_tuser);
      handle_q <= s_handle;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      high_water <= '0;
      clr_cnt    <= '0;
    end else begin
      free_count <= free_count_next;
      high_water <= high_water_next;
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      handle_out <= res_handle;
      status     <= res_status;
    end
  end

  assign m_tdata = M_DATA_W'({status, handle_out});

endmodule

// ===== rtl/id_pool_allocator.sv =====
// Result path: the request beat is captured with registered map and stack reads,
//   the update commits in S_EXEC and the result beat goes to the output register
//   once it is free; no new request is taken before the commit, and the block
//   stalls while the output beat waits.
// Reset: synchronous, active high; then a clearing pass over every map entry
//   zeroes the in-use map with s_tready low. Counters start at zero.
module id_pool_allocator #(
  parameter int ID_COUNT = ipa_pkg::ID_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ipa_pkg::S_DATA_W-1:0] s_tdata,  // [9:0] handle_in, rest zero
  input  logic                         s_tuser,  // [0] operation
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ipa_pkg::M_DATA_W-1:0] m_tdata   // [9:0] handle_out, [11:10] status
);
  import ipa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ipa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipa_datapath #(
    .ID_COUNT (ID_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/ipa_checker.sv =====
`include "id_pool_allocator_defines.svh"

module ipa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [ipa_pkg::S_DATA_W-1:0] s_tdata,
  input logic                         s_tuser,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [ipa_pkg::M_DATA_W-1:0] m_tdata
);
  import ipa_pkg::*;

  logic s_beat;
  assign s_beat = s_tvalid && s_tready && (s_tuser || !s_tuser) && (s_tdata == s_tdata);

  // map clearing pass holds off requests right after reset
  `IPA_ASSERT_ALWAYS(a_clear_after_rst, !($past(rst) && !rst && s_tready))

  // one request at a time: no back-to-back request beats
  `IPA_ASSERT_NEXT(a_one_at_a_time, s_beat, !s_tready)

  // failed requests carry handle zero; padding bits stay zero
  `IPA_ASSERT_ALWAYS(a_fail_zero, !m_tvalid || (m_tdata[11:10] == ST_OK) ||
                     (m_tdata[9:0] == '0))
  `IPA_ASSERT_ALWAYS(a_pad_zero, !m_tvalid || (m_tdata[15:12] == '0))

  // stalled result beat holds
  `IPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind id_pool_allocator ipa_checker u_ipa_checker (.*);
